>>> rtl/smla_pkg.sv
// Shared types and constants for the Stokes moment lag accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
package smla_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LAGS    = 16;
    localparam int LAG_W       = 4;
    localparam int N_W         = 5;
    localparam int ACC_W       = 64;
    localparam int CNT_W       = 40;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int K_W         = LAG_W + 4;

    localparam logic [1:0] ACT_ACCUM = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] KIND_VEC   = 2'd0;
    localparam logic [1:0] KIND_OUTER = 2'd1;
    localparam logic [1:0] KIND_LAG   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEC,
        ST_OUTER,
        ST_OLD_READ,
        ST_OLD_LOAD,
        ST_LAG,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_READ1,
        ST_READ2,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic           capture;
        logic           do_vec;
        logic           issue;
        logic           issue_lag;
        logic [K_W-1:0] k;
        logic           ring_oldest;
        logic           load_oldest;
        logic           read_sel;
        logic           load_out;
        logic           clear;
    } cmd_t;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic           do_lag;
        logic           out_busy;
    } status_t;

endpackage

>>> rtl/stokes_moment_lag_accumulator_top.sv
// Top level of the Stokes moment lag accumulator.
// Depends on smla_pkg, smla_ctrl and smla_datapath.
//
// Input channel: in_valid/in_stall carry one transaction (action, sample,
// read selectors). Output channel: out_valid/out_stall carry one result per
// read transaction. cfg_write_en/cfg_write_data set lags_in_use; the user must
// write it only while idle, as the block does not enforce it. One transaction
// is worked on at a time; in_stall is high while busy. Accumulate: accept, a
// vector/count step, the 16 outer products, then, once the ring is full, a
// fetch of the oldest sample and the lag products, then the drain states
// ST_DRAIN1 and ST_DRAIN2. The single multiplier, one product per cycle, sets
// the length of an accumulate. Read: ST_READ1, ST_READ2, then the result
// register loads once the output is not busy; clear: ST_CLEAR.
// Results sit in an output register; a stalled result holds and only a
// following read waits for it. Reset clears all sums, counts, the flag and
// lags_in_use; the lag memory is cleared through per-entry valid bits.
module stokes_moment_lag_accumulator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           action,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_i,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_q,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_u,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_v,
    input  logic [1:0]                           read_kind,
    input  logic [smla_pkg::LAG_W-1:0]           read_lag,
    input  logic [1:0]                           read_row,
    input  logic [1:0]                           read_col,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [smla_pkg::ACC_W-1:0]    value,
    output logic [smla_pkg::CNT_W-1:0]           sample_total,
    output logic [smla_pkg::CNT_W-1:0]           lag_total,
    output logic                                 saturated,
    input  logic                                 cfg_write_en,
    input  logic [smla_pkg::N_W-1:0]             cfg_write_data
);
    import smla_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    smla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Storage and arithmetic
    smla_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .stokes_i       (stokes_i),
        .stokes_q       (stokes_q),
        .stokes_u       (stokes_u),
        .stokes_v       (stokes_v),
        .read_kind      (read_kind),
        .read_lag       (read_lag),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .value          (value),
        .sample_total   (sample_total),
        .lag_total      (lag_total),
        .saturated      (saturated)
    );

endmodule

>>> rtl/smla_ctrl.sv
// Sequencer for the Stokes moment lag accumulator.
// Depends on smla_pkg; drives the datapath through cmd_t and reads status_t.
module smla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       action,
    input  smla_pkg::status_t status,
    output logic             in_stall,
    output smla_pkg::cmd_t   cmd
);
    import smla_pkg::*;

    state_t         state_reg, state_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [LAG_W-1:0] last_lag;

    assign last_lag = LAG_W'(status.n - N_W'(1));

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.k      = k_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    k_next      = '0;
                    case (action)
                        ACT_ACCUM: state_next = ST_VEC;
                        ACT_READ:  state_next = ST_READ1;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_VEC:
            begin
                cmd.do_vec = 1'b1;
                state_next = ST_OUTER;
            end
            ST_OUTER:
            begin
                cmd.issue = 1'b1;
                k_next    = k_reg + K_W'(1);
                if (k_reg[3:0] == 4'hF)
                begin
                    k_next     = '0;
                    state_next = status.do_lag ? ST_OLD_READ : ST_DRAIN1;
                end
            end
            ST_OLD_READ:
            begin
                cmd.ring_oldest = 1'b1;
                state_next      = ST_OLD_LOAD;
            end
            ST_OLD_LOAD:
            begin
                cmd.load_oldest = 1'b1;
                state_next      = ST_LAG;
            end
            ST_LAG:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_lag = 1'b1;
                k_next        = k_reg + K_W'(1);
                if (k_reg[K_W-1:4] == last_lag && k_reg[3:0] == 4'hF)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_IDLE;
            ST_READ1:
            begin
                cmd.read_sel = 1'b1;
                state_next   = ST_READ2;
            end
            ST_READ2:
            begin
                cmd.read_sel = 1'b1;
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/smla_datapath.sv
// Accumulators, sample ring, lag memory and multiply-accumulate pipeline.
// Depends on smla_pkg; sequenced by smla_ctrl.
module smla_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  smla_pkg::cmd_t                       cmd,
    output smla_pkg::status_t                    status,
    input  logic                                 cfg_write_en,
    input  logic [smla_pkg::N_W-1:0]             cfg_write_data,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_i,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_q,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_u,
    input  logic signed [smla_pkg::SAMPLE_BITS-1:0] stokes_v,
    input  logic [1:0]                           read_kind,
    input  logic [smla_pkg::LAG_W-1:0]           read_lag,
    input  logic [1:0]                           read_row,
    input  logic [1:0]                           read_col,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic signed [smla_pkg::ACC_W-1:0]    value,
    output logic [smla_pkg::CNT_W-1:0]           sample_total,
    output logic [smla_pkg::CNT_W-1:0]           lag_total,
    output logic                                 saturated
);
    import smla_pkg::*;

    typedef logic signed [3:0][SAMPLE_BITS-1:0] sample_t;
    localparam int DEPTH = MAX_LAGS * 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_LAGS);

    function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                              input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        logic [ACC_W:0] r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            r = {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        else
            r = {1'b0, s[ACC_W-1:0]};
        return r;
    endfunction

    logic [N_W-1:0]         lags_reg;
    logic [N_W-1:0]         n;
    sample_t                sample_reg;
    logic [1:0]             kind_reg;
    logic [LAG_W-1:0]       lag_reg;
    logic [1:0]             row_reg, col_reg;

    logic signed [ACC_W-1:0] vec_reg [4];
    logic signed [ACC_W-1:0] outer_reg [16];
    logic signed [ACC_W-1:0] lag_mem [DEPTH];
    logic [DEPTH-1:0]        lag_valid_reg;
    sample_t                 ring [MAX_LAGS];
    logic [LAG_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        seen_reg, updates_reg;
    logic                    flag_reg;

    sample_t                 ring_rd_reg, oldest_reg;
    logic signed [ACC_W-1:0] mem_rd_reg;
    logic                    vld_rd_reg;
    logic                    v1_reg, lag1_reg, v2_reg, lag2_reg;
    logic [K_W-1:0]          k1_reg, k2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc2_reg;

    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] value_reg;
    logic [CNT_W-1:0]        sample_total_reg, lag_total_reg;
    logic                    saturated_reg;

    logic [CNT_W-1:0]        seen_next;
    logic                    seen_sat;
    logic [LAG_W-1:0]        wr_ptr;
    logic [N_W-1:0]          ptr_inc;
    logic [N_W-1:0]          ptr_sum;
    logic [LAG_W-1:0]        ring_addr;
    logic [K_W-1:0]          mem_addr;
    logic [3:0]              outer_addr;
    logic signed [ACC_W-1:0] outer_rd;
    logic signed [SAMPLE_BITS-1:0] op_a, op_b;
    logic [ACC_W:0]          mac_sum;
    logic [ACC_W:0]          vec_sum [4];
    logic signed [ACC_W-1:0] read_value;

    // Clamp lag count to capacity
    assign n = (lags_reg > N_MAX) ? N_MAX : lags_reg;

    // Saturating sample count and ring write slot
    assign seen_sat  = (seen_reg == CNT_MAX);
    assign seen_next = seen_sat ? CNT_MAX : seen_reg + CNT_W'(1);
    assign wr_ptr    = ({1'b0, ptr_reg} >= n) ? '0 : ptr_reg;
    assign ptr_inc   = {1'b0, wr_ptr} + N_W'(1);

    assign status.n        = n;
    assign status.do_lag   = (n != '0) && (seen_reg >= CNT_W'(n));
    assign status.out_busy = out_valid_reg && out_stall;

    // Ring and lag memory addresses
    assign ptr_sum    = {1'b0, ptr_reg} + {1'b0, cmd.k[K_W-1:4]};
    assign ring_addr  = cmd.ring_oldest ? ptr_reg :
                        LAG_W'((ptr_sum >= n) ? ptr_sum - n : ptr_sum);
    assign mem_addr   = cmd.read_sel ? {lag_reg, row_reg, col_reg} : cmd.k;
    assign outer_addr = cmd.read_sel ? {row_reg, col_reg} : k1_reg[3:0];
    assign outer_rd   = outer_reg[outer_addr];

    // Multiplier operands
    always_comb
    begin
        if (lag1_reg)
        begin
            op_a = ring_rd_reg[k1_reg[3:2]];
            op_b = oldest_reg[k1_reg[1:0]];
        end
        else
        begin
            op_a = sample_reg[k1_reg[3:2]];
            op_b = sample_reg[k1_reg[1:0]];
        end
    end

    assign mac_sum = sat_add(acc2_reg, ACC_W'(prod_reg));

    always_comb
    begin
        for (int e = 0; e < 4; e++)
            vec_sum[e] = sat_add(vec_reg[e], ACC_W'(signed'(sample_reg[e])));
    end

    // Select the word for a read
    always_comb
    begin
        case (kind_reg)
            KIND_VEC:   read_value = vec_reg[row_reg];
            KIND_OUTER: read_value = outer_rd;
            KIND_LAG:   read_value = vld_rd_reg ? mem_rd_reg : '0;
            default:    read_value = '0;
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lags_reg <= '0;
        else if (cfg_write_en)
            lags_reg <= cfg_write_data;
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= {stokes_v, stokes_u, stokes_q, stokes_i};
            kind_reg   <= read_kind;
            lag_reg    <= read_lag;
            row_reg    <= read_row;
            col_reg    <= read_col;
        end
    end

    // Ring write and registered ring read
    always_ff @(posedge clk)
    begin
        if (cmd.do_vec && n != '0)
            ring[wr_ptr] <= sample_reg;
        ring_rd_reg <= ring[ring_addr];
        if (cmd.load_oldest)
            oldest_reg <= ring_rd_reg;
    end

    // Lag memory: registered read, write from the last pipeline stage
    always_ff @(posedge clk)
    begin
        mem_rd_reg <= lag_mem[mem_addr];
        if (v2_reg && lag2_reg)
            lag_mem[k2_reg] <= mac_sum[ACC_W-1:0];
    end

    // Multiply-accumulate pipeline payload
    always_ff @(posedge clk)
    begin
        k1_reg   <= cmd.k;
        k2_reg   <= k1_reg;
        prod_reg <= op_a * op_b;
        if (lag1_reg)
            acc2_reg <= vld_rd_reg ? mem_rd_reg : '0;
        else
            acc2_reg <= outer_rd;
    end

    // Pipeline control, accumulators, counters and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            lag1_reg      <= 1'b0;
            lag2_reg      <= 1'b0;
            vld_rd_reg    <= 1'b0;
            lag_valid_reg <= '0;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            updates_reg   <= '0;
            flag_reg      <= 1'b0;
            for (int e = 0; e < 4; e++)
                vec_reg[e] <= '0;
            for (int e = 0; e < 16; e++)
                outer_reg[e] <= '0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            lag1_reg   <= cmd.issue_lag;
            v2_reg     <= v1_reg;
            lag2_reg   <= lag1_reg;
            vld_rd_reg <= lag_valid_reg[mem_addr];
            if (cmd.clear)
            begin
                lag_valid_reg <= '0;
                ptr_reg       <= '0;
                seen_reg      <= '0;
                updates_reg   <= '0;
                flag_reg      <= 1'b0;
                for (int e = 0; e < 4; e++)
                    vec_reg[e] <= '0;
                for (int e = 0; e < 16; e++)
                    outer_reg[e] <= '0;
            end
            else
            begin
                if (cmd.do_vec)
                begin
                    for (int e = 0; e < 4; e++)
                        vec_reg[e] <= vec_sum[e][ACC_W-1:0];
                    seen_reg <= seen_next;
                    if (n != '0)
                        ptr_reg <= (ptr_inc >= n) ? '0 : ptr_inc[LAG_W-1:0];
                    if (n != '0 && seen_next >= CNT_W'(n))
                    begin
                        if (updates_reg != CNT_MAX)
                            updates_reg <= updates_reg + CNT_W'(1);
                    end
                    if (seen_sat || vec_sum[0][ACC_W] || vec_sum[1][ACC_W] ||
                        vec_sum[2][ACC_W] || vec_sum[3][ACC_W] ||
                        (n != '0 && seen_next >= CNT_W'(n) && updates_reg == CNT_MAX))
                        flag_reg <= 1'b1;
                end
                if (v2_reg)
                begin
                    if (lag2_reg)
                        lag_valid_reg[k2_reg] <= 1'b1;
                    else
                        outer_reg[k2_reg[3:0]] <= mac_sum[ACC_W-1:0];
                    if (mac_sum[ACC_W])
                        flag_reg <= 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_reg        <= read_value;
            sample_total_reg <= seen_reg;
            lag_total_reg    <= updates_reg;
            saturated_reg    <= flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign sample_total = sample_total_reg;
    assign lag_total    = lag_total_reg;
    assign saturated    = saturated_reg;

endmodule

>>> tb/sv/tb.sv
// Testbench for the Stokes moment lag accumulator top level.
// Depends on smla_pkg and stokes_moment_lag_accumulator_top; stands alone otherwise.
// Directed and random transactions are checked against an in-bench moment predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smla_pkg::*;

    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam longint unsigned COUNT_TOP = (64'd1 << CNT_W) - 64'd1;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [1:0]                    act;
        logic signed [SAMPLE_BITS-1:0] si;
        logic signed [SAMPLE_BITS-1:0] sq;
        logic signed [SAMPLE_BITS-1:0] su;
        logic signed [SAMPLE_BITS-1:0] sv;
        logic [1:0]                    kind;
        logic [LAG_W-1:0]              lag;
        logic [1:0]                    row;
        logic [1:0]                    col;
    } stokes_txn_t;

    typedef struct {
        logic signed [ACC_W-1:0] word;
        logic [CNT_W-1:0]        samples;
        logic [CNT_W-1:0]        updates;
        logic                    sat;
    } read_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_ACCUM;
    logic signed [SAMPLE_BITS-1:0] stokes_i = '0;
    logic signed [SAMPLE_BITS-1:0] stokes_q = '0;
    logic signed [SAMPLE_BITS-1:0] stokes_u = '0;
    logic signed [SAMPLE_BITS-1:0] stokes_v = '0;
    logic [1:0] read_kind = KIND_VEC;
    logic [LAG_W-1:0] read_lag = '0;
    logic [1:0] read_row = '0;
    logic [1:0] read_col = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [ACC_W-1:0] value;
    logic [CNT_W-1:0] sample_total;
    logic [CNT_W-1:0] lag_total;
    logic saturated;
    logic cfg_write_en = 1'b0;
    logic [N_W-1:0] cfg_write_data = '0;

    // Predictor state
    logic [N_W-1:0]  lags_reg;
    longint          vec_acc [4];
    longint          outer_acc [16];
    longint          lag_acc [MAX_LAGS*16];
    longint          history [MAX_LAGS][4];
    int unsigned     hist_ptr;
    longint unsigned sample_cnt;
    longint unsigned lag_cnt;
    bit              sticky;

    read_word_t expected_reads[$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    always #6 clk = ~clk;

    stokes_moment_lag_accumulator_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .stokes_i       (stokes_i),
        .stokes_q       (stokes_q),
        .stokes_u       (stokes_u),
        .stokes_v       (stokes_v),
        .read_kind      (read_kind),
        .read_lag       (read_lag),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .sample_total   (sample_total),
        .lag_total      (lag_total),
        .saturated      (saturated),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Saturating 64-bit add, sets the sticky flag on overflow
    function automatic longint sat_sum(input longint a, input longint b);
        logic signed [ACC_W:0] t;
        t = a;
        t = t + b;
        if (t[ACC_W] != t[ACC_W-1])
        begin
            sticky = 1'b1;
            return t[ACC_W] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return t[ACC_W-1:0];
    endfunction

    function automatic longint unsigned bump_count(input longint unsigned n);
        if (n >= COUNT_TOP)
        begin
            sticky = 1'b1;
            return COUNT_TOP;
        end
        return n + 1;
    endfunction

    function automatic void wipe_moments();
        foreach (vec_acc[k]) vec_acc[k] = 0;
        foreach (outer_acc[k]) outer_acc[k] = 0;
        foreach (lag_acc[k]) lag_acc[k] = 0;
        foreach (history[k, e]) history[k][e] = 0;
        hist_ptr = 0;
        sample_cnt = 0;
        lag_cnt = 0;
        sticky = 1'b0;
    endfunction

    function automatic void add_sample(input stokes_txn_t t);
        longint s [4];
        int unsigned n;
        int unsigned oldest;
        int unsigned other;
        s[0] = t.si;
        s[1] = t.sq;
        s[2] = t.su;
        s[3] = t.sv;
        n = (lags_reg > MAX_LAGS) ? MAX_LAGS : lags_reg;
        for (int r = 0; r < 4; r++)
        begin
            vec_acc[r] = sat_sum(vec_acc[r], s[r]);
            for (int c = 0; c < 4; c++)
                outer_acc[r*4+c] = sat_sum(outer_acc[r*4+c], s[r] * s[c]);
        end
        sample_cnt = bump_count(sample_cnt);
        if (n == 0)
            return;
        // Restart the pointer if the lag count was lowered under it
        if (hist_ptr >= n)
            hist_ptr = 0;
        for (int e = 0; e < 4; e++)
            history[hist_ptr][e] = s[e];
        hist_ptr++;
        if (hist_ptr >= n)
            hist_ptr = 0;
        if (sample_cnt >= n)
        begin
            oldest = hist_ptr;
            for (int l = 0; l < n; l++)
            begin
                other = (hist_ptr + l) % n;
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        lag_acc[l*16+r*4+c] = sat_sum(lag_acc[l*16+r*4+c],
                            history[other][r] * history[oldest][c]);
            end
            lag_cnt = bump_count(lag_cnt);
        end
    endfunction

    // Work out the effect of one accepted transaction
    function automatic void predict_transaction(input stokes_txn_t t);
        read_word_t w;
        case (t.act)
            ACT_ACCUM: add_sample(t);
            ACT_CLEAR: wipe_moments();
            ACT_READ:
            begin
                w.word = 0;
                if (t.kind == KIND_VEC)
                    w.word = vec_acc[t.row];
                else if (t.kind == KIND_OUTER)
                    w.word = outer_acc[t.row*4+t.col];
                else if (t.kind == KIND_LAG && t.lag < MAX_LAGS)
                    w.word = lag_acc[t.lag*16+t.row*4+t.col];
                w.samples = sample_cnt[CNT_W-1:0];
                w.updates = lag_cnt[CNT_W-1:0];
                w.sat = sticky;
                expected_reads.push_back(w);
            end
            default: ;
        endcase
    endfunction

    // Check each result and drive the receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
                report_mismatch("result with no read pending");
            else
            begin
                read_word_t w;
                w = expected_reads.pop_front();
                if (value !== w.word)
                    report_mismatch($sformatf("value %0d, want %0d", value, w.word));
                if (sample_total !== w.samples)
                    report_mismatch($sformatf("sample_total %0d, want %0d",
                        sample_total, w.samples));
                if (lag_total !== w.updates)
                    report_mismatch($sformatf("lag_total %0d, want %0d", lag_total, w.updates));
                if (saturated !== w.sat)
                    report_mismatch($sformatf("saturated %0b, want %0b", saturated, w.sat));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Send one transaction and hold it until accepted
    task automatic send_item(input stokes_txn_t t);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= t.act;
        stokes_i  <= t.si;
        stokes_q  <= t.sq;
        stokes_u  <= t.su;
        stokes_v  <= t.sv;
        read_kind <= t.kind;
        read_lag  <= t.lag;
        read_row  <= t.row;
        read_col  <= t.col;
        do
            @(posedge clk);
        while (in_stall);
        predict_transaction(t);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return SAMPLE_BITS'($urandom_range(15) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic stokes_txn_t fill_txn(input logic [1:0] act);
        stokes_txn_t t;
        t.act  = act;
        t.si   = pick_sample();
        t.sq   = pick_sample();
        t.su   = pick_sample();
        t.sv   = pick_sample();
        t.kind = 2'($urandom);
        t.lag  = LAG_W'($urandom);
        t.row  = 2'($urandom);
        t.col  = 2'($urandom);
        return t;
    endfunction

    task automatic accum(input int i, input int q, input int u, input int v);
        stokes_txn_t t;
        t = fill_txn(ACT_ACCUM);
        t.si = SAMPLE_BITS'(i);
        t.sq = SAMPLE_BITS'(q);
        t.su = SAMPLE_BITS'(u);
        t.sv = SAMPLE_BITS'(v);
        send_item(t);
    endtask

    task automatic read_word(input logic [1:0] kind, input int lag, input int row,
                             input int col);
        stokes_txn_t t;
        t = fill_txn(ACT_READ);
        t.kind = kind;
        t.lag = LAG_W'(lag);
        t.row = 2'(row);
        t.col = 2'(col);
        send_item(t);
    endtask

    task automatic send_action(input logic [1:0] act);
        send_item(fill_txn(act));
    endtask

    // Wait until every read has returned and any accumulate has finished
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the lag count while idle; clear when raised so no unwritten slot is used
    task automatic set_lags(input logic [N_W-1:0] n);
        int unsigned was;
        int unsigned now;
        drain();
        was = (lags_reg > MAX_LAGS) ? MAX_LAGS : lags_reg;
        now = (n > MAX_LAGS) ? MAX_LAGS : n;
        cfg_write_en   <= 1'b1;
        cfg_write_data <= n;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        lags_reg = n;
        if (now > was)
            send_action(ACT_CLEAR);
    endtask

    task automatic test_extremes();
        read_word(KIND_VEC, 0, 0, 3);
        accum(-32768, -32768, 32767, 32767);
        accum(32767, -32768, 0, -1);
        send_action(ACT_NONE);
        read_word(KIND_VEC, 5, 0, 1);
        read_word(KIND_VEC, 0, 3, 2);
        read_word(KIND_OUTER, 0, 0, 0);
        read_word(KIND_OUTER, 15, 3, 3);
        read_word(KIND_OUTER, 0, 1, 2);
        read_word(KIND_NONE, 3, 2, 1);
        read_word(KIND_LAG, 0, 0, 0);
    endtask

    task automatic test_lag_products();
        set_lags(5'd2);
        accum(1000, -2, 3, -4);
        read_word(KIND_LAG, 0, 0, 0);
        accum(-32768, 32767, 7, 9);
        accum(5, 6, -7, 8);
        read_word(KIND_LAG, 0, 1, 2);
        read_word(KIND_LAG, 1, 0, 1);
        read_word(KIND_LAG, 1, 3, 3);
        read_word(KIND_LAG, 15, 3, 3);
    endtask

    task automatic test_over_capacity_and_restart();
        set_lags(5'd31);
        for (int k = 0; k < 5; k++)
            send_item(fill_txn(ACT_ACCUM));
        set_lags(5'd3);
        for (int k = 0; k < 4; k++)
            send_item(fill_txn(ACT_ACCUM));
        read_word(KIND_LAG, 2, 1, 0);
        read_word(KIND_LAG, 0, 2, 2);
    endtask

    task automatic test_clear();
        send_action(ACT_CLEAR);
        read_word(KIND_VEC, 0, 1, 0);
        read_word(KIND_LAG, 0, 0, 0);
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        int pick;
        stokes_txn_t t;
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 48)
                t = fill_txn(ACT_ACCUM);
            else if (pick < 96)
            begin
                t = fill_txn(ACT_READ);
                // Favor lag reads, within the lags in use most of the time
                if ($urandom_range(3) != 0)
                begin
                    t.kind = KIND_LAG;
                    if ($urandom_range(3) != 0 && lags_reg != 0)
                        t.lag = LAG_W'($urandom_range(
                            ((lags_reg > MAX_LAGS) ? MAX_LAGS : lags_reg) - 1));
                end
            end
            else if (pick < 98)
                t = fill_txn(ACT_NONE);
            else
                t = fill_txn(ACT_CLEAR);
            send_item(t);
        end
    endtask

    initial
    begin
        lags_reg = '0;
        wipe_moments();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_lag_products();
        test_over_capacity_and_restart();
        test_clear();
        set_lags(5'd4);
        test_random(170, 0, 0);
        set_lags(5'd16);
        test_random(170, 79, 0);
        set_lags(5'd7);
        test_random(170, 0, 79);
        set_lags(5'd1);
        test_random(170, 16, 16);
        set_lags(5'd0);
        test_random(90, 0, 0);
        set_lags(5'd31);
        test_random(90, 16, 16);
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("stokes_moment_lag_accumulator_top test passed");
        else
            $display("stokes_moment_lag_accumulator_top test failed");
        $finish;
    end

    // Bound the run
    initial
    begin
        #40_000_000;
        $display("stokes_moment_lag_accumulator_top test failed");
        $finish;
    end

endmodule
